>>> rtl/cics_pkg.sv
// Shared definitions for the categorical inverse-CDF sampler.
// Field widths, parameter defaults, operation codes and the
// controller/datapath command and status structs. No dependencies.
package cics_pkg;

    // Default sizing
    localparam int MAX_CATEGORIES_DEF = 64;
    localparam int NUM_DISTS_DEF      = 64;
    localparam int PROB_BITS_DEF      = 16;

    // Fixed port field widths
    localparam int OP_W       = 1;
    localparam int DIST_IDX_W = 6;
    localparam int CAT_IDX_W  = 6;
    localparam int IN_PROB_W  = 16;
    localparam int UNIF_W     = 16;
    localparam int OUT_CAT_W  = 7;
    localparam int CFG_W      = 7;

    // Categories in use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 1'b1;

    // Controller -> datapath
    typedef struct packed {
        logic wr;        // store one probability
        logic load;      // latch a sample request
        logic fetch;     // issue first table read
        logic step;      // accumulate one entry, read the next unless done
        logic out_load;  // move finished category into output register
    } t_ctrl_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic walk_done; // current step is the last one
        logic out_free;  // output register can take a result
    } t_dp_status;

endpackage

>>> rtl/categorical_inverse_cdf_sampler.sv
// Categorical sampler by inverse CDF over a table of probability columns.
// Write item: stored at its transfer edge, one write per cycle while idle, no result.
// Sample item: result valid after the table walk and output load, n the
// category returned (1..K), one table read per walk step but the last; no
// new item transfers until the result is loaded, which waits on an unread one.
// Synchronous active-low reset clears control and sets K to 64, not the table.
module categorical_inverse_cdf_sampler
    import cics_pkg::*;
#(
    parameter int MAX_CATEGORIES = MAX_CATEGORIES_DEF,
    parameter int NUM_DISTS      = NUM_DISTS_DEF,
    parameter int PROB_BITS      = PROB_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [DIST_IDX_W-1:0] i_dist_index,
    input  logic [CAT_IDX_W-1:0]  i_category_index,
    input  logic [IN_PROB_W-1:0]  i_prob_value,
    input  logic [UNIF_W-1:0]     i_uniform_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_CAT_W-1:0]  o_sampled_category
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    cics_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    cics_dp #(
        .MAX_CATEGORIES (MAX_CATEGORIES),
        .NUM_DISTS      (NUM_DISTS),
        .PROB_BITS      (PROB_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_dist_index       (i_dist_index),
        .i_category_index   (i_category_index),
        .i_prob_value       (i_prob_value),
        .i_uniform_value    (i_uniform_value),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_sampled_category (o_sampled_category)
    );

`ifndef ASSERT_OFF
    // At most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.wr, w_cmd.load, w_cmd.fetch, w_cmd.step, w_cmd.out_load}))
        else $error("controller issued overlapping commands");

    // A result is only loaded when the output register has room
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_status.out_free)
        else $error("result loaded over an untaken result");

    // A sample transfer closes the input until its result is loaded for output
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_operation == OP_SAMPLE)) |=> !o_in_ready)
        else $error("input reopened during a sample walk");

    // Categories are 1-based
    a_cat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sampled_category != '0))
        else $error("zero category presented");
`endif

endmodule

>>> rtl/cics_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module cics_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cics_ctrl.sv
// Sequencing FSM for the sampler: accepts items, drives the table walk
// and hands results to the output register. Uses cics_pkg.
module cics_ctrl
    import cics_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [OP_W-1:0]       i_operation,
    output logic                  o_in_ready,
    input  t_dp_status            i_status,
    output t_ctrl_cmd             o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.wr       = w_accept && (i_operation == OP_WRITE);
        o_cmd.load     = w_accept && (i_operation == OP_SAMPLE);
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_WALK;
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_status.walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/cics_dp.sv
// Sampler datapath: config register, probability table, address walk,
// accumulator, category counter and output register.
// Uses cics_pkg and cics_ram.
module cics_dp
    import cics_pkg::*;
#(
    parameter int MAX_CATEGORIES = MAX_CATEGORIES_DEF,
    parameter int NUM_DISTS      = NUM_DISTS_DEF,
    parameter int PROB_BITS      = PROB_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic [DIST_IDX_W-1:0] i_dist_index,
    input  logic [CAT_IDX_W-1:0]  i_category_index,
    input  logic [IN_PROB_W-1:0]  i_prob_value,
    input  logic [UNIF_W-1:0]     i_uniform_value,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_CAT_W-1:0]  o_sampled_category
);

    localparam int DEPTH   = MAX_CATEGORIES * NUM_DISTS;
    localparam int AW      = $clog2(DEPTH);
    localparam int DIST_W  = (NUM_DISTS > 1) ? $clog2(NUM_DISTS) : 1;
    localparam int CAT_W   = $clog2(MAX_CATEGORIES + 1);
    localparam int KCMP_W  = (CAT_W > CFG_W) ? CAT_W : CFG_W;
    localparam int ACC_W   = (PROB_BITS + CAT_W > UNIF_W) ? (PROB_BITS + CAT_W) : UNIF_W;
    localparam int LUT_N   = 2 ** DIST_IDX_W;

    logic [CFG_W-1:0]     r_cfg;
    logic [AW-1:0]        r_addr;
    logic [UNIF_W-1:0]    r_u;
    logic [CAT_W-1:0]     r_k;
    logic [CAT_W-1:0]     r_cat;
    logic [ACC_W-1:0]     r_acc;
    logic                 r_out_valid;
    logic [OUT_CAT_W-1:0] r_out_cat;

    logic [DIST_W-1:0]    w_dist_lut [LUT_N];
    logic [AW-1:0]        w_base;
    logic [AW-1:0]        w_waddr;
    logic                 w_row_ok;
    logic [CAT_W-1:0]     w_k_eff;
    logic [PROB_BITS-1:0] w_rdata;
    logic [ACC_W-1:0]     w_acc_new;
    logic [CAT_W-1:0]     w_cat_new;
    logic                 w_done;
    logic                 w_re;

    // Column index reduced modulo the column count, as a constant table
    for (genvar g = 0; g < LUT_N; g++) begin : g_dist_lut
        assign w_dist_lut[g] = DIST_W'(g % NUM_DISTS);
    end

    // Write address and row range check
    assign w_base   = AW'(w_dist_lut[i_dist_index]) * AW'(MAX_CATEGORIES);
    assign w_waddr  = w_base + AW'(i_category_index);
    assign w_row_ok = 32'(i_category_index) < 32'(MAX_CATEGORIES);

    // Effective K: zero reads as one, saturate at the column height
    always_comb begin
        priority if (r_cfg == '0) begin
            w_k_eff = CAT_W'(1);
        end else if (KCMP_W'(r_cfg) > KCMP_W'(MAX_CATEGORIES)) begin
            w_k_eff = CAT_W'(MAX_CATEGORIES);
        end else begin
            w_k_eff = CAT_W'(r_cfg);
        end
    end

    // One walk step: add the entry that just came out of the table
    assign w_acc_new = ((r_cat == '0) ? '0 : r_acc) + ACC_W'(w_rdata);
    assign w_cat_new = r_cat + CAT_W'(1);
    assign w_done    = (w_cat_new >= r_k) || !(ACC_W'(r_u) > w_acc_new);
    assign w_re      = i_cmd.fetch || (i_cmd.step && !w_done);

    assign o_status.walk_done = w_done;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    cics_ram #(
        .WIDTH (PROB_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr && w_row_ok),
        .i_waddr (w_waddr),
        .i_wdata (PROB_BITS'(i_prob_value)),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= w_base;
            r_u    <= i_uniform_value;
            r_k    <= w_k_eff;
            r_cat  <= '0;
            r_acc  <= '0;
        end else if (i_cmd.fetch) begin
            r_addr <= r_addr + AW'(1);
        end else if (i_cmd.step) begin
            r_addr <= r_addr + AW'(1);
            r_acc  <= w_acc_new;
            r_cat  <= w_cat_new;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cat <= OUT_CAT_W'(r_cat);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_sampled_category = r_out_cat;

endmodule
